// ===== rtl/sliding_window_average_top_assert.svh =====
// ----------------------------------------------------------------------------
// Sliding window average: assertion macros
// Shared helpers for concurrent assertions clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication
`define SWA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding window average: same-cycle check failed");

// Next-cycle implication
`define SWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window average: next-cycle check failed");

`endif

// ===== rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window average package
// Widths, sizes and the job record passed from the front end to the divider.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int WINDOW_MAX  = 64;
  localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
  localparam int HELD_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  // One pending division: running sum over the count it covers
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [HELD_BITS-1:0]       held;
  } swa_job_t;

endpackage

// ===== rtl/swa_front.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: front end
// Accepts samples, keeps the sample ring, running sum and count, and emits
// one division job per sample. Also owns the window length register.
// ----------------------------------------------------------------------------
module swa_front
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          in_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [HELD_BITS-1:0]          cfg_window_length,
  input  logic                          job_space,
  output logic                          job_valid,
  output swa_job_t                      job
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic                          state_r, state_nxt;
  logic [SLOT_BITS-1:0]          slot_r, slot_nxt;
  logic [SLOT_BITS-1:0]          use_slot_r;
  logic [HELD_BITS-1:0]          held_r, held_nxt;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [HELD_BITS-1:0]          wlen_r, wlen_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

  logic                          accept;
  logic                          cfg_wr;
  logic                          window_full;
  logic [HELD_BITS-1:0]          slot_inc;
  logic signed [SUM_BITS-1:0]    sample_ext;
  logic signed [SUM_BITS-1:0]    old_ext;

  assign in_full   = (state_r != ST_IDLE) || !job_space;
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Clamp the written window length into 1..WINDOW_MAX
  always_comb begin
    if (cfg_window_length == '0) begin
      wlen_nxt = HELD_BITS'(1);
    end else if (cfg_window_length > HELD_BITS'(WINDOW_MAX)) begin
      wlen_nxt = HELD_BITS'(WINDOW_MAX);
    end else begin
      wlen_nxt = cfg_window_length;
    end
  end

  // Update sum and count from the sample and the slot it replaces
  assign window_full = (held_r >= wlen_r);
  assign sample_ext  = {{(SUM_BITS-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign old_ext     = {{(SUM_BITS-SAMPLE_BITS){old_r[SAMPLE_BITS-1]}}, old_r};
  assign slot_inc    = {1'b0, use_slot_r} + HELD_BITS'(1);

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
        if (window_full) begin
          sum_nxt = sum_r - old_ext + sample_ext;
        end else begin
          sum_nxt  = sum_r + sample_ext;
          held_nxt = held_r + HELD_BITS'(1);
        end
        slot_nxt = (slot_inc >= wlen_r) ? '0 : slot_inc[SLOT_BITS-1:0];
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign job_valid = (state_r == ST_UPDATE);
  assign job.sum   = sum_nxt;
  assign job.held  = held_nxt;

  // Control state; a window write clears the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      held_r  <= '0;
      sum_r   <= '0;
      wlen_r  <= HELD_BITS'(1);
    end else if (cfg_wr) begin
      wlen_r  <= wlen_nxt;
      slot_r  <= '0;
      held_r  <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r   <= in_sample;
      use_slot_r <= slot_r;
    end
  end

  // Sample ring: read the slot on accept, overwrite it on update
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r <= ring[slot_r];
    end
    if (state_r == ST_UPDATE) begin
      ring[use_slot_r] <= sample_r;
    end
  end

endmodule

// ===== rtl/swa_queue.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: job queue
// Two-entry queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module swa_queue
  import swa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  input  swa_job_t wr_job,
  output logic     wr_space,
  input  logic     rd_pop,
  output logic     rd_valid,
  output swa_job_t rd_job
);

  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  swa_job_t   slots [2];
  logic       do_wr;
  logic       do_rd;

  assign wr_space = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = slots[rd_ptr_r];
  assign do_wr    = wr_valid && wr_space;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== rtl/swa_divider.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: divider back end
// Bit-serial signed division of the sum by the count, truncated toward zero,
// with a one-entry result register on the output side.
// ----------------------------------------------------------------------------
module swa_divider
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  swa_job_t                      job,
  output logic                          job_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [HELD_BITS-1:0]          out_samples_held
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [STEP_BITS-1:0]   step_r;
  logic                   neg_r;
  logic [SUM_BITS-1:0]    quot_r;
  logic [HELD_BITS-1:0]   rem_r;
  logic [HELD_BITS-1:0]   div_r;
  logic                   out_valid_r;

  logic [SUM_BITS-1:0]    mag;
  logic [HELD_BITS:0]     rem_sh;
  logic [HELD_BITS:0]     rem_diff;
  logic                   q_bit;
  logic [SUM_BITS-1:0]    avg_wide;
  logic                   out_free;

  assign job_pop   = (state_r == ST_IDLE) && job_valid;
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;

  // Magnitude of the incoming sum
  assign mag = job.sum[SUM_BITS-1] ? SUM_BITS'(~job.sum + 1'b1) : SUM_BITS'(job.sum);

  // One restoring step: remainder stays below the divisor
  assign rem_sh   = {rem_r, quot_r[SUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign q_bit    = (rem_sh >= {1'b0, div_r});

  // Restore the sign of the quotient
  assign avg_wide = neg_r ? SUM_BITS'(~quot_r + 1'b1) : quot_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == STEP_BITS'(SUM_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        step_r <= step_r + STEP_BITS'(1);
      end else begin
        step_r <= '0;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: load, iterate, deliver
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          neg_r  <= job.sum[SUM_BITS-1];
          quot_r <= mag;
          rem_r  <= '0;
          div_r  <= job.held;
        end
      end
      ST_DIV: begin
        rem_r  <= q_bit ? rem_diff[HELD_BITS-1:0] : rem_sh[HELD_BITS-1:0];
        quot_r <= {quot_r[SUM_BITS-2:0], q_bit};
      end
      ST_DONE: begin
        if (out_free) begin
          out_average      <= avg_wide[SAMPLE_BITS-1:0];
          out_samples_held <= div_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/sliding_window_average_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: top level
// An accepted sample passes the front end, job queue and divider to the out_ ports.
// The bit-serial divider (22 steps plus load and hand-off) bounds the sample rate;
// the front end refuses a new sample while it updates or while the queue is full.
// Reset: synchronous, active low; window length 1, store empty, no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_average_top
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [HELD_BITS-1:0]          out_samples_held,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [HELD_BITS-1:0]          cfg_window_length
);

  logic     fe_job_valid;
  swa_job_t fe_job;
  logic     q_space;
  logic     q_valid;
  swa_job_t q_job;
  logic     q_pop;

  // Accept samples and build division jobs
  swa_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_sample         (in_sample),
    .in_full           (in_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .job_space         (q_space),
    .job_valid         (fe_job_valid),
    .job               (fe_job)
  );

  // Decouple front end and divider
  swa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_job_valid),
    .wr_job   (fe_job),
    .wr_space (q_space),
    .rd_pop   (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  // Divide and deliver
  swa_divider u_divider (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (q_job),
    .job_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

endmodule

// ===== rtl/swa_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: port checker
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
`include "sliding_window_average_top_assert.svh"

module swa_checker
  import swa_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_push,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic signed [SAMPLE_BITS-1:0] out_average,
  input logic [HELD_BITS-1:0]          out_samples_held
);

  // A shown result always covers between one and a full window of samples
  `SWA_ASSERT_NOW(a_held_range, !out_empty, (out_samples_held != '0) && (out_samples_held <= HELD_BITS'(WINDOW_MAX)))

  // An accepted beat blocks the input for the update cycle that follows
  `SWA_ASSERT_NEXT(a_full_after_push, in_push && !in_full, in_full)

  // A result not taken stays shown and unchanged
  `SWA_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_average) && $stable(out_samples_held))

endmodule

bind sliding_window_average_top swa_checker u_swa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_average      (out_average),
  .out_samples_held (out_samples_held)
);
